// ===== rtl/servo_pkg.sv =====
// servo_pkg: shared types and constants of the servo position controller
// holds the request and response payload structs, operation codes and pulse limits
// no dependencies
`default_nettype none

package servo_pkg;

   // request operation codes
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // per-channel register selects
   localparam logic [2:0] REG_ATTACH = 3'd0;
   localparam logic [2:0] REG_MIN    = 3'd1;
   localparam logic [2:0] REG_MAX    = 3'd2;
   localparam logic [2:0] REG_DEG    = 3'd3;
   localparam logic [2:0] REG_PULSE  = 3'd4;

   // control register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLES_PER_US  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESCALE_SHIFT = 1'd1;
   localparam logic [7:0] CYCLES_PER_US_RESET  = 8'd80;
   localparam logic [2:0] PRESCALE_SHIFT_RESET = 3'd5;

   // pulse limits in microseconds
   localparam int PULSE_W = 12;
   localparam logic [PULSE_W-1:0] PULSE_ABS_MIN = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_ABS_MID = 12'd1500;
   localparam logic [PULSE_W-1:0] PULSE_ABS_MAX = 12'd2500;
   localparam logic [PULSE_W-1:0] SPAN_RESET    = 12'd2000;

   // degree constants
   localparam logic [7:0]  DEG_FULL  = 8'd180;
   localparam logic [15:0] DEG_ERROR = 16'd255;

   // compare value and divider sizes
   localparam int CMP_W     = 20;
   localparam int PROD_W    = 20;
   localparam int QUO_W     = 19;
   localparam int DIV_STEPS = 19;
   localparam int DIV_CNT_W = 5;

   // divide by 180 as ((x >> 2) * 186414) >> 23, exact for x below 2^19
   localparam int RECIP_IN_W      = 17;
   localparam int DEG_RECIP_W     = 18;
   localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 18'd186414;
   localparam int DEG_RECIP_SHIFT = 23;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  channel;
      logic [2:0]  register_select;
      logic [15:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [15:0]      read_data;
      logic             bad_channel;
      logic [2:0]       active_slot;
      logic [CMP_W-1:0] compare_value;
      logic             slot_output_on;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/multi_channel_servo_position_controller.sv =====
// multi_channel_servo_position_controller: register-mapped servo channels with slot ticks
// one item at a time: reads, attach/min/max writes and ticks pass S_FETCH and S_DONE;
// pulse writes add S_MUL and S_CMP; degree writes run S_MUL, S_RECIP, S_POST, S_MUL, S_CMP;
// degree reads run the shared 12x8 multiplier and the 19-step shared restoring divider; the
// next transfer is taken once the result sits in the output register
// synchronous reset restores all channels and control registers at once, no clearing pass
`default_nettype none

module multi_channel_servo_position_controller #(
   parameter int NUM_CHANNELS = 5
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire servo_pkg::req_item_type          req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output servo_pkg::rsp_item_type               rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [servo_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [servo_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [2:0] NUM_CH = 3'(NUM_CHANNELS);
   localparam int PW = servo_pkg::PULSE_W;
   localparam int RP_W = servo_pkg::RECIP_IN_W + servo_pkg::DEG_RECIP_W;

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_MUL, S_DIV, S_RECIP, S_POST, S_CMP, S_DONE
   } state_type;

   // control state
   state_type                   state_ff, state_in;
   logic [2:0]                  slot_ff, slot_in;
   logic [7:0]                  cycles_ff;
   logic [2:0]                  shift_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        cmp_phase_ff, cmp_phase_in;
   logic [servo_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // payload and working registers
   servo_pkg::req_item_type     item_ff, item_in;
   servo_pkg::rsp_item_type     res_ff, res_in;
   servo_pkg::rsp_item_type     rsp_ff, rsp_in;
   logic [PW-1:0]               mul_a_ff, mul_a_in;
   logic [7:0]                  mul_b_ff, mul_b_in;
   logic [servo_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [servo_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [PW-1:0]               rem_ff, rem_in;
   logic [PW-1:0]               den_ff, den_in;
   logic [PW-1:0]               pw_new_ff, pw_new_in;

   // channel registers
   logic                        attached_ff   [NUM_CHANNELS];
   logic [PW-1:0]               min_pulse_ff  [NUM_CHANNELS];
   logic [PW-1:0]               max_pulse_ff  [NUM_CHANNELS];
   logic [PW-1:0]               span_ff       [NUM_CHANNELS];
   logic [PW-1:0]               pulse_ff      [NUM_CHANNELS];
   logic [servo_pkg::CMP_W-1:0] compare_ff    [NUM_CHANNELS];

   // channel read port and write controls
   logic [2:0]                  addr;
   logic                        ch_ok;
   logic [IDX_W-1:0]            idx;
   logic                        rd_att;
   logic [PW-1:0]               rd_min, rd_max, rd_span, rd_pulse;
   logic [servo_pkg::CMP_W-1:0] rd_cmp;
   logic                        wr_attach, wr_min, wr_max, wr_pulse;
   logic [PW-1:0]               lim_val, span_val;
   logic [servo_pkg::CMP_W-1:0] cmp_val;

   // datapath helpers
   logic [15:0]                 wdata;
   logic [PW-1:0]               clamp_pulse;
   logic [PW:0]                 rem_sh;
   logic [servo_pkg::PROD_W-1:0] cyc;
   logic [RP_W-1:0]             recip_prod;
   logic                        start_cmp;
   logic [PW-1:0]               start_val;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared read address: the slot on a tick, else the addressed channel
   assign addr  = (item_ff.req_type == servo_pkg::REQ_TICK) ? slot_ff : item_ff.channel;
   assign ch_ok = (addr < NUM_CH);
   assign idx   = ch_ok ? addr[IDX_W-1:0] : '0;

   assign rd_att   = attached_ff[idx];
   assign rd_min   = min_pulse_ff[idx];
   assign rd_max   = max_pulse_ff[idx];
   assign rd_span  = span_ff[idx];
   assign rd_pulse = pulse_ff[idx];
   assign rd_cmp   = compare_ff[idx];

   assign wdata = item_ff.write_data;

   // direct pulse write clamped to the channel limits
   always_comb begin
      if (wdata < {4'd0, rd_min}) begin
         clamp_pulse = rd_min;
      end else if (wdata > {4'd0, rd_max}) begin
         clamp_pulse = rd_max;
      end else begin
         clamp_pulse = wdata[PW-1:0];
      end
   end

   // divider step and compare conversion
   assign rem_sh = {rem_ff, quo_ff[servo_pkg::QUO_W-1]};
   assign cyc    = prod_ff >> shift_ff;

   // degree write quotient by 180 through a reciprocal multiply
   assign recip_prod =
      {{servo_pkg::DEG_RECIP_W{1'b0}}, prod_ff[servo_pkg::RECIP_IN_W+1:2]} *
      {{servo_pkg::RECIP_IN_W{1'b0}}, servo_pkg::DEG_RECIP};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      cmp_phase_in = cmp_phase_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      pw_new_in    = pw_new_ff;
      wr_attach    = 1'b0;
      wr_min       = 1'b0;
      wr_max       = 1'b0;
      wr_pulse     = 1'b0;
      lim_val      = servo_pkg::PULSE_ABS_MID;
      span_val     = rd_span;
      cmp_val      = '0;
      start_cmp    = 1'b0;
      start_val    = rd_pulse;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_FETCH;
               if (req_data.req_type == servo_pkg::REQ_TICK) begin
                  slot_in = (slot_ff >= NUM_CH) ? 3'd0 : slot_ff + 3'd1;
               end
            end
         end

         S_FETCH: begin
            res_in             = '0;
            res_in.active_slot = slot_ff;
            state_in           = S_DONE;
            case (item_ff.req_type)
               servo_pkg::REQ_READ: begin
                  if (!ch_ok) begin
                     res_in.bad_channel = 1'b1;
                     if (item_ff.register_select == servo_pkg::REG_DEG) begin
                        res_in.read_data = servo_pkg::DEG_ERROR;
                     end
                  end else begin
                     case (item_ff.register_select)
                        servo_pkg::REG_ATTACH: res_in.read_data = {15'd0, rd_att};
                        servo_pkg::REG_MIN:    res_in.read_data = {4'd0, rd_min};
                        servo_pkg::REG_MAX:    res_in.read_data = {4'd0, rd_max};
                        servo_pkg::REG_PULSE:  res_in.read_data = {4'd0, rd_pulse};
                        servo_pkg::REG_DEG: begin
                           // 180 * (pulse - min) / span through the shared unit
                           if (rd_span != '0 && rd_pulse >= rd_min) begin
                              mul_a_in     = rd_pulse - rd_min;
                              mul_b_in     = servo_pkg::DEG_FULL;
                              den_in       = rd_span;
                              cmp_phase_in = 1'b0;
                              state_in     = S_MUL;
                           end
                        end
                        default: res_in.read_data = '0;
                     endcase
                  end
               end

               servo_pkg::REQ_WRITE: begin
                  if (!ch_ok) begin
                     res_in.bad_channel = 1'b1;
                  end else begin
                     case (item_ff.register_select)
                        servo_pkg::REG_ATTACH: wr_attach = 1'b1;
                        servo_pkg::REG_MIN: begin
                           wr_min = 1'b1;
                           if (wdata < {4'd0, servo_pkg::PULSE_ABS_MIN}) begin
                              lim_val = servo_pkg::PULSE_ABS_MIN;
                           end else if (wdata > {4'd0, servo_pkg::PULSE_ABS_MID}) begin
                              lim_val = servo_pkg::PULSE_ABS_MID;
                           end else begin
                              lim_val = wdata[PW-1:0];
                           end
                           span_val = rd_max - lim_val;
                        end
                        servo_pkg::REG_MAX: begin
                           wr_max = 1'b1;
                           if (wdata < {4'd0, servo_pkg::PULSE_ABS_MID}) begin
                              lim_val = servo_pkg::PULSE_ABS_MID;
                           end else if (wdata > {4'd0, servo_pkg::PULSE_ABS_MAX}) begin
                              lim_val = servo_pkg::PULSE_ABS_MAX;
                           end else begin
                              lim_val = wdata[PW-1:0];
                           end
                           span_val = lim_val - rd_min;
                        end
                        servo_pkg::REG_DEG: begin
                           if (wdata == 16'd0) begin
                              start_cmp = 1'b1;
                              start_val = rd_min;
                           end else if (wdata > {8'd0, servo_pkg::DEG_FULL}) begin
                              start_cmp = 1'b1;
                              start_val = rd_max;
                           end else begin
                              // deg * span / 180, then add min
                              mul_a_in     = rd_span;
                              mul_b_in     = wdata[7:0];
                              cmp_phase_in = 1'b0;
                              state_in     = S_MUL;
                           end
                        end
                        servo_pkg::REG_PULSE: begin
                           start_cmp = 1'b1;
                           start_val = clamp_pulse;
                        end
                        default: ;
                     endcase
                  end
               end

               servo_pkg::REQ_TICK: begin
                  if (ch_ok && rd_att) begin
                     res_in.slot_output_on = 1'b1;
                     res_in.compare_value  = rd_cmp;
                  end
               end

               default: ;
            endcase
         end

         S_MUL: begin
            prod_in = {8'd0, mul_a_ff} * {12'd0, mul_b_ff};
            quo_in  = prod_in[servo_pkg::QUO_W-1:0];
            rem_in  = '0;
            cnt_in  = '0;
            if (cmp_phase_ff) begin
               state_in = S_CMP;
            end else if (item_ff.req_type == servo_pkg::REQ_WRITE) begin
               state_in = S_RECIP;
            end else begin
               state_in = S_DIV;
            end
         end

         // one restoring division step per cycle
         S_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = PW'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[servo_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[PW-1:0];
               quo_in = {quo_ff[servo_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == servo_pkg::DIV_CNT_W'(servo_pkg::DIV_STEPS - 1)) begin
               state_in = S_POST;
            end
         end

         // quotient of the degree product by 180
         S_RECIP: begin
            quo_in   = servo_pkg::QUO_W'(recip_prod >> servo_pkg::DEG_RECIP_SHIFT);
            state_in = S_POST;
         end

         S_POST: begin
            if (item_ff.req_type == servo_pkg::REQ_READ) begin
               if (quo_ff > {11'd0, servo_pkg::DEG_FULL}) begin
                  res_in.read_data = {8'd0, servo_pkg::DEG_FULL};
               end else begin
                  res_in.read_data = quo_ff[15:0];
               end
               state_in = S_DONE;
            end else begin
               start_cmp = 1'b1;
               start_val = quo_ff[PW-1:0] + rd_min;
            end
         end

         // pulse to timer compare, saturating at zero
         S_CMP: begin
            wr_pulse = 1'b1;
            cmp_val  = (cyc == '0) ? '0 : cyc - 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // kick off the compare conversion of a new pulse width
      if (start_cmp) begin
         pw_new_in    = start_val;
         mul_a_in     = start_val;
         mul_b_in     = cycles_ff;
         cmp_phase_in = 1'b1;
         state_in     = S_MUL;
      end
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_phase_ff <= 1'b0;
         cnt_ff       <= '0;
         cycles_ff    <= servo_pkg::CYCLES_PER_US_RESET;
         shift_ff     <= servo_pkg::PRESCALE_SHIFT_RESET;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_phase_ff <= cmp_phase_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               servo_pkg::CSR_CYCLES_PER_US:  cycles_ff <= csr_data;
               servo_pkg::CSR_PRESCALE_SHIFT: shift_ff  <= csr_data[2:0];
               default: ;
            endcase
         end
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      pw_new_ff <= pw_new_in;
   end

   // per-channel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            attached_ff[i]  <= 1'b0;
            min_pulse_ff[i] <= servo_pkg::PULSE_ABS_MIN;
            max_pulse_ff[i] <= servo_pkg::PULSE_ABS_MAX;
            span_ff[i]      <= servo_pkg::SPAN_RESET;
            pulse_ff[i]     <= servo_pkg::PULSE_ABS_MID;
            compare_ff[i]   <= '0;
         end
      end else begin
         if (wr_attach) begin
            attached_ff[idx] <= wdata[0];
         end
         if (wr_min) begin
            min_pulse_ff[idx] <= lim_val;
            span_ff[idx]      <= span_val;
         end
         if (wr_max) begin
            max_pulse_ff[idx] <= lim_val;
            span_ff[idx]      <= span_val;
         end
         if (wr_pulse) begin
            pulse_ff[idx]   <= pw_new_ff;
            compare_ff[idx] <= cmp_val;
         end
      end
   end

   // checks
   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_FETCH)
      else $error("transfer did not start a fetch");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < servo_pkg::DIV_CNT_W'(servo_pkg::DIV_STEPS))
      else $error("divider ran past its step count");

   a_cmp_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> $past(state_ff) == S_MUL && cmp_phase_ff)
      else $error("compare conversion without a multiply");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= NUM_CH)
      else $error("slot beyond the idle slot");

   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_channel |-> !rsp_data.slot_output_on &&
         rsp_data.compare_value == '0)
      else $error("bad channel result drives a slot");

endmodule

`default_nettype wire
